>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the matrix inverse block.
// Each macro builds one labeled concurrent assertion on clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/m3i_pkg.sv
// Package for the 3x3 matrix inverse: widths, pipeline depth and the
// determinant delay line record. No dependencies.
`timescale 1ns / 1ps

package m3i_pkg;

	localparam int ELEM_W  = 32;          // matrix element width
	localparam int NELEM   = 9;           // elements per matrix
	localparam int COF_W   = 65;          // exact cofactor width
	localparam int DET_W   = 98;          // exact determinant width
	localparam int DMAG_W  = 97;          // determinant magnitude width
	localparam int CMP_W   = 129;         // divider remainder width
	localparam int NSTEP   = 32;          // quotient bits, one per stage
	localparam int NL      = NSTEP + 3;   // determinant line length after s5

	// Determinant record carried alongside the divider stages.
	typedef struct packed {
		logic              zero;
		logic              neg;
		logic [DMAG_W-1:0] mag;
		logic [ELEM_W-1:0] dout;
		logic              dovf;
	} det_line_t;

endpackage

>>> src/m3i_cof_lane.sv
// One cofactor lane: p*q - r*s, exact, over two registered stages.
// Depends on m3i_pkg.
`timescale 1ns / 1ps

module m3i_cof_lane (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [m3i_pkg::ELEM_W-1:0] p,
	input  logic signed [m3i_pkg::ELEM_W-1:0] q,
	input  logic signed [m3i_pkg::ELEM_W-1:0] r,
	input  logic signed [m3i_pkg::ELEM_W-1:0] s,
	output logic signed [m3i_pkg::COF_W-1:0]  cof
);
	import m3i_pkg::*;

	logic signed [2*ELEM_W-1:0] pq_s1;
	logic signed [2*ELEM_W-1:0] rs_s1;
	logic signed [COF_W-1:0]    cof_s2;

	// Both products in the first stage, the difference in the second.
	always_ff @(posedge clk) begin
		if (en) begin
			pq_s1  <= p * q;
			rs_s1  <= r * s;
			cof_s2 <= COF_W'(pq_s1) - COF_W'(rs_s1);
		end
	end

	assign cof = cof_s2;

endmodule

>>> src/m3i_div_lane.sv
// One divider lane: cofactor * 2^(2*FRAC_BITS) / determinant, truncated,
// saturated to 32 bits. One quotient bit per stage. Depends on m3i_pkg.
`timescale 1ns / 1ps

module m3i_div_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [m3i_pkg::COF_W-1:0]  cof,
	input  logic                              dneg,
	input  logic [m3i_pkg::DMAG_W-1:0]        dmag [0:m3i_pkg::NL],
	output logic [m3i_pkg::ELEM_W-1:0]        res,
	output logic                              ovf
);
	import m3i_pkg::*;

	localparam int NW = COF_W - 1 + 2 * FRAC_BITS;

	logic [COF_W-1:0]  cabs;
	logic [NW-1:0]     nmag_s0;
	logic              neg_s0;
	logic [CMP_W-1:0]  dsh;
	logic [CMP_W-1:0]  dsat;
	logic [CMP_W-1:0]  rem_q [0:NSTEP];
	logic [ELEM_W-1:0] quo_q [0:NSTEP];
	logic              neg_q [0:NSTEP];
	logic              sat_q [0:NSTEP];
	logic [ELEM_W-1:0] res_q;
	logic              ovf_q;

	// Numerator magnitude and result sign.
	assign cabs = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s0 <= NW'(cabs[COF_W-2:0]) << (2 * FRAC_BITS);
			neg_s0  <= cof[COF_W-1] ^ dneg;
		end
	end

	// Saturation test: the magnitude bound is 2^31 for positive results
	// and 2^31 + 1 for negative ones, in units of the determinant.
	assign dsh  = CMP_W'(dmag[1]) << (ELEM_W - 1);
	assign dsat = dsh + CMP_W'(dmag[1]);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= CMP_W'(nmag_s0);
			quo_q[0] <= '0;
			neg_q[0] <= neg_s0;
			sat_q[0] <= neg_s0 ? (CMP_W'(nmag_s0) >= dsat) : (CMP_W'(nmag_s0) >= dsh);
		end
	end

	// Restoring division, one quotient bit per stage from the top bit down.
	for (genvar j = 0; j < NSTEP; j++) begin : g_step
		localparam int K = NSTEP - 1 - j;
		logic [CMP_W-1:0] dk;
		logic             fit;
		assign dk  = CMP_W'(dmag[2+j]) << K;
		assign fit = rem_q[j] >= dk;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j+1] <= fit ? rem_q[j] - dk : rem_q[j];
				quo_q[j+1] <= quo_q[j] | (ELEM_W'(fit) << K);
				neg_q[j+1] <= neg_q[j];
				sat_q[j+1] <= sat_q[j];
			end
		end
	end

	// Sign and saturation.
	always_ff @(posedge clk) begin
		if (en) begin
			if (sat_q[NSTEP]) begin
				res_q <= neg_q[NSTEP] ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
			end else begin
				res_q <= neg_q[NSTEP] ? ELEM_W'(-quo_q[NSTEP]) : quo_q[NSTEP];
			end
			ovf_q <= sat_q[NSTEP];
		end
	end

	assign res = res_q;
	assign ovf = ovf_q;

endmodule

>>> src/matrix3_inverse_top.sv
// Channel   Dir  tdata / tuser                                Transfer
// s_axis    in   9 elements r0c0..r2c2, 32 bits each          tvalid & tready
// m_axis    out  9 inverse elements, determinant; tuser flags tvalid & tready
//
// One matrix enters per cycle while no result waits at the output.
// The divider lanes produce one quotient bit per stage.
// Reset clears only the stage valid bits; no clearing pass is needed.
// A result held at the output stalls the whole pipeline and drops s_tready.
// Depends on m3i_pkg, m3i_cof_lane, m3i_div_lane and assert_macros.svh.
`timescale 1ns / 1ps

module matrix3_inverse_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [287:0] s_tdata,   // a_r0c0, a_r0c1, a_r0c2, a_r1c0 .. a_r2c2
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [319:0] m_tdata,   // inv_r0c0 .. inv_r2c2, determinant
	output logic [1:0]   m_tuser    // singular, overflow
);
	import m3i_pkg::*;

	`include "assert_macros.svh"

	logic                     en;
	logic signed [ELEM_W-1:0] a [NELEM];
	logic signed [COF_W-1:0]  cof [NELEM];
	logic signed [ELEM_W-1:0] a0_s1 [3];
	logic signed [ELEM_W-1:0] a0_s2 [3];
	logic signed [COF_W-1:0]  cof_s3 [NELEM];
	logic signed [COF_W-1:0]  cof_s4 [NELEM];
	logic signed [COF_W-1:0]  cof_s5 [NELEM];
	logic signed [COF_W-1:0]  plo_s3 [3];
	logic signed [COF_W-1:0]  phi_s3 [3];
	logic signed [DET_W-1:0]  det_s4;
	logic [3:0]               v_q;
	logic                     vl_q [0:NL];
	det_line_t                line_q [0:NL];
	logic [DMAG_W-1:0]        dmag [0:NL];
	logic [DMAG_W-1:0]        dshr;
	logic [ELEM_W-1:0]        dout_c;
	logic                     dovf_c;
	logic [ELEM_W-1:0]        res [NELEM];
	logic                     lovf [NELEM];
	logic                     any_ovf;
	logic [ELEM_W-1:0]        inv_q [NELEM];
	logic [ELEM_W-1:0]        det_q;
	logic                     sing_q;
	logic                     ovf_q;
	logic                     out_valid_q;

	// The whole pipeline moves unless a result waits at the output.
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	for (genvar i = 0; i < NELEM; i++) begin : g_unpack
		assign a[i] = s_tdata[i*ELEM_W +: ELEM_W];
	end

	// Cofactor lanes: C[i][j] = a[i+1][j+1]*a[i+2][j+2] - a[i+1][j+2]*a[i+2][j+1].
	for (genvar i = 0; i < 3; i++) begin : g_cr
		for (genvar j = 0; j < 3; j++) begin : g_cc
			localparam int I1 = (i + 1) % 3;
			localparam int I2 = (i + 2) % 3;
			localparam int J1 = (j + 1) % 3;
			localparam int J2 = (j + 2) % 3;
			m3i_cof_lane u_cof (
				.clk (clk),
				.en  (en),
				.p   (a[I1*3+J1]),
				.q   (a[I2*3+J2]),
				.r   (a[I1*3+J2]),
				.s   (a[I2*3+J1]),
				.cof (cof[i*3+j])
			);
		end
	end

	// First row follows the cofactor lanes; cofactors wait for the determinant.
	always_ff @(posedge clk) begin
		if (en) begin
			a0_s1  <= a[0:2];
			a0_s2  <= a0_s1;
			cof_s3 <= cof;
			cof_s4 <= cof_s3;
			cof_s5 <= cof_s4;
		end
	end

	// Determinant terms, each cofactor split into a signed high and unsigned low part.
	for (genvar j = 0; j < 3; j++) begin : g_det
		always_ff @(posedge clk) begin
			if (en) begin
				plo_s3[j] <= COF_W'(a0_s2[j])
					* COF_W'($signed({1'b0, cof[j][ELEM_W-1:0]}));
				phi_s3[j] <= COF_W'(a0_s2[j])
					* COF_W'($signed(cof[j][COF_W-1:ELEM_W]));
			end
		end
	end

	// Merge the three row terms into the exact determinant.
	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= (DET_W'(phi_s3[0]) <<< ELEM_W) + DET_W'(plo_s3[0])
				+ (DET_W'(phi_s3[1]) <<< ELEM_W) + DET_W'(plo_s3[1])
				+ (DET_W'(phi_s3[2]) <<< ELEM_W) + DET_W'(plo_s3[2]);
		end
	end

	// Determinant line: magnitude and sign, then the saturated output value.
	assign dshr = line_q[0].mag >> (2 * FRAC_BITS);

	always_comb begin
		if (line_q[0].neg) begin
			dovf_c = dshr > DMAG_W'({1'b1, {(ELEM_W-1){1'b0}}});
			dout_c = dovf_c ? {1'b1, {(ELEM_W-1){1'b0}}} : ELEM_W'(-dshr);
		end else begin
			dovf_c = dshr > DMAG_W'({(ELEM_W-1){1'b1}});
			dout_c = dovf_c ? {1'b0, {(ELEM_W-1){1'b1}}} : dshr[ELEM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0].zero <= (det_s4 == '0);
			line_q[0].neg  <= det_s4[DET_W-1];
			line_q[0].mag  <= det_s4[DET_W-1] ? DMAG_W'(-det_s4) : DMAG_W'(det_s4);
			line_q[0].dout <= '0;
			line_q[0].dovf <= 1'b0;
			line_q[1] <= '{zero: line_q[0].zero, neg: line_q[0].neg,
				mag: line_q[0].mag, dout: dout_c, dovf: dovf_c};
			for (int k = 2; k <= NL; k++) begin
				line_q[k] <= line_q[k-1];
			end
		end
	end

	for (genvar k = 0; k <= NL; k++) begin : g_dmag
		assign dmag[k] = line_q[k].mag;
	end

	// Divider lanes; inverse element (r, c) takes cofactor (c, r).
	for (genvar r = 0; r < 3; r++) begin : g_dr
		for (genvar c = 0; c < 3; c++) begin : g_dc
			m3i_div_lane #(
				.FRAC_BITS (FRAC_BITS)
			) u_div (
				.clk  (clk),
				.en   (en),
				.cof  (cof_s5[c*3+r]),
				.dneg (line_q[0].neg),
				.dmag (dmag),
				.res  (res[r*3+c]),
				.ovf  (lovf[r*3+c])
			);
		end
	end

	always_comb begin
		any_ovf = line_q[NL].dovf;
		for (int i = 0; i < NELEM; i++) begin
			any_ovf = any_ovf | lovf[i];
		end
	end

	// Output register: identity for a singular matrix, else the lane results.
	always_ff @(posedge clk) begin
		if (en) begin
			if (line_q[NL].zero) begin
				for (int i = 0; i < NELEM; i++) begin
					inv_q[i] <= (i % 4 == 0) ? ELEM_W'(64'd1 << FRAC_BITS) : '0;
				end
				det_q  <= '0;
				sing_q <= 1'b1;
				ovf_q  <= 1'b0;
			end else begin
				inv_q  <= res;
				det_q  <= line_q[NL].dout;
				sing_q <= 1'b0;
				ovf_q  <= any_ovf;
			end
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k <= NL; k++) begin
				vl_q[k] <= 1'b0;
			end
		end else if (en) begin
			v_q         <= {v_q[2:0], s_tvalid};
			vl_q[0]     <= v_q[3];
			for (int k = 1; k <= NL; k++) begin
				vl_q[k] <= vl_q[k-1];
			end
			out_valid_q <= vl_q[NL];
		end
	end

	for (genvar i = 0; i < NELEM; i++) begin : g_pack
		assign m_tdata[i*ELEM_W +: ELEM_W] = inv_q[i];
	end
	assign m_tdata[NELEM*ELEM_W +: ELEM_W] = det_q;
	assign m_tuser  = {ovf_q, sing_q};
	assign m_tvalid = out_valid_q;

	// Checks on the block's own logic.
	`ASSERT_SAME(a_sing_no_ovf, m_tvalid && m_tuser[0], !m_tuser[1], "singular result flags overflow")
	`ASSERT_SAME(a_sing_det_zero, m_tvalid && m_tuser[0], m_tdata[319:288] == 32'd0, "singular det nonzero")
	`ASSERT_SAME(a_stall_blocks, m_tvalid && !m_tready, !s_tready, "input taken while output is stalled")
	`ASSERT_NEXT(a_hold_out, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

>>> test/tb.sv
// Self-checking testbench for matrix3_inverse_top: streams 3x3 Q16.16 matrices
// through the block and compares each result with an exact 128-bit predictor.
// Depends on m3i_pkg and the RTL of the matrix inverse block.
`timescale 1ns / 1ps

module tb;
	import m3i_pkg::*;

	localparam int FRAC  = 16;
	localparam int LAT   = 41;
	localparam int LIMIT = 2000000;
	localparam int NRAND = 1900;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [127:0] wide_t;

	typedef struct {
		elem_t inv [9];
		elem_t det;
		logic  sing;
		logic  ovf;
	} inverse_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [287:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [319:0] m_tdata;
	logic [1:0]   m_tuser;

	logic [287:0] matrix_q [$];
	inverse_t     inverse_q [$];
	int           errors = 0;
	int           results_seen = 0;
	int           singular_seen = 0;
	int           overflow_seen = 0;
	int           cycles = 0;
	bit           stim_done = 0;
	bit           hold_long = 0;
	bit           in_fire = 0;

	matrix3_inverse_top #(.FRAC_BITS(FRAC)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Clock and a single reset at the start.
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Saturate an exact value to a 32-bit element, noting any clipping.
	function automatic elem_t clip32(input wide_t v, inout logic ovf);
		if (v > 128'sh7FFFFFFF) begin
			ovf = 1;
			return 32'h7FFFFFFF;
		end
		if (v < -128'sh80000000) begin
			ovf = 1;
			return 32'h80000000;
		end
		return elem_t'(v);
	endfunction

	// Exact inverse by adjugate over determinant, truncating toward zero.
	function automatic inverse_t invert(input logic [287:0] m);
		wide_t    a [3][3];
		wide_t    cof [3][3];
		wide_t    d;
		wide_t    num;
		wide_t    q;
		wide_t    mag;
		inverse_t res;
		res.ovf = 0;
		for (int i = 0; i < 9; i++)
			a[i/3][i%3] = wide_t'($signed(m[i*32 +: 32]));
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				cof[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
					- a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
		d = a[0][0]*cof[0][0] + a[0][1]*cof[0][1] + a[0][2]*cof[0][2];
		res.sing = (d == 0);
		if (res.sing) begin
			for (int i = 0; i < 9; i++)
				res.inv[i] = (i % 4 == 0) ? elem_t'(1 << FRAC) : '0;
			res.det = '0;
			return res;
		end
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				// SystemVerilog signed division already truncates toward zero.
				num = cof[c][r] <<< (2*FRAC);
				q = num / d;
				res.inv[r*3+c] = clip32(q, res.ovf);
			end
		mag = (d < 0 ? -d : d) >> (2*FRAC);
		res.det = clip32(d < 0 ? -mag : mag, res.ovf);
		return res;
	endfunction

	function automatic logic [287:0] pack_matrix(input elem_t e [9]);
		logic [287:0] v;
		for (int i = 0; i < 9; i++)
			v[i*32 +: 32] = e[i];
		return v;
	endfunction

	function automatic elem_t rand_elem();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return elem_t'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
			2: return elem_t'($signed($urandom_range(0, 32'h7FF)) - 32'sh400);
			3: return $urandom_range(0, 3) == 0 ? 32'h80000000 : 32'h7FFFFFFF;
			4: return $urandom_range(0, 1) ? elem_t'(1 << FRAC) : '0;
			default: return elem_t'($signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000);
		endcase
	endfunction

	// Stimulus: directed corner matrices, then random ones.
	initial begin
		elem_t e [9];
		int    k;
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// Identity, zero matrix, a scaled identity and extreme values.
		for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? elem_t'(1 << FRAC) : '0;
		matrix_q.push_back(pack_matrix(e));
		for (int i = 0; i < 9; i++) e[i] = '0;
		matrix_q.push_back(pack_matrix(e));
		for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? elem_t'(2 << FRAC) : '0;
		matrix_q.push_back(pack_matrix(e));
		for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? elem_t'(1) : '0;
		matrix_q.push_back(pack_matrix(e));
		for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 32'h7FFFFFFF : '0;
		matrix_q.push_back(pack_matrix(e));
		for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 32'h80000000 : '0;
		matrix_q.push_back(pack_matrix(e));
		for (int i = 0; i < 9; i++) e[i] = 32'h80000000;
		matrix_q.push_back(pack_matrix(e));
		for (int i = 0; i < 9; i++) e[i] = 32'h7FFFFFFF;
		matrix_q.push_back(pack_matrix(e));
		for (int i = 0; i < 9; i++) e[i] = 32'hFFFFFFFF;
		matrix_q.push_back(pack_matrix(e));
		// Tiny nonzero determinant: diagonal of raw 1, 1, 2^16.
		for (int i = 0; i < 9; i++) e[i] = '0;
		e[0] = 1; e[4] = 1; e[8] = elem_t'(1 << FRAC);
		matrix_q.push_back(pack_matrix(e));
		// Positive determinant: a row swap of the identity with the last diagonal negated.
		for (int i = 0; i < 9; i++) e[i] = '0;
		e[1] = elem_t'(1 << FRAC); e[3] = elem_t'(1 << FRAC); e[8] = elem_t'(-(1 << FRAC));
		matrix_q.push_back(pack_matrix(e));
		// Alternating extremes with a full bit pattern.
		for (int i = 0; i < 9; i++) e[i] = (i % 2) ? 32'h80000000 : 32'h55555555;
		matrix_q.push_back(pack_matrix(e));
		for (int i = 0; i < 9; i++) e[i] = (i % 2) ? 32'hAAAAAAAA : 32'h7FFFFFFF;
		matrix_q.push_back(pack_matrix(e));
		// Random part; some matrices have a repeated row to force singularity.
		for (int n = 0; n < NRAND; n++) begin
			for (int i = 0; i < 9; i++) e[i] = rand_elem();
			if ($urandom_range(0, 9) == 0) begin
				k = $urandom_range(0, 2);
				for (int j = 0; j < 3; j++) e[((k+1)%3)*3 + j] = e[k*3 + j];
			end
			matrix_q.push_back(pack_matrix(e));
		end
		wait (matrix_q.size() == 0 && !s_tvalid);
		stim_done = 1;
	end

	// Driver: bursts of transfers separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata  <= '0;
		end else if (s_tvalid && !in_fire) begin
			// Hold the offered matrix until it is taken.
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			s_tvalid <= 0;
		end else if (matrix_q.size() > 0) begin
			s_tvalid <= 1;
			s_tdata  <= matrix_q.pop_front();
			if (burst_left == 0) begin
				burst_left <= $urandom_range(1, 30);
				gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			s_tvalid <= 0;
		end
	end

	// Receiver: random stall pattern, plus one long hold-off mid-run.
	int hold_cnt = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else if (results_seen == 300 && !hold_long) begin
			hold_long <= 1;
			hold_cnt  <= 200;
			m_tready  <= 0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 0;
		end else if ((cycles / 512) % 3 == 0) begin
			m_tready <= 1;
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// Monitor: predict on each input transfer, check on each output transfer.
	always @(posedge clk) begin
		inverse_t exp_res;
		elem_t    got;
		int       bad;
		bad = 0;
		cycles  <= cycles + 1;
		in_fire <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			inverse_q.push_back(invert(s_tdata));
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (inverse_q.size() == 0) begin
				bad++;
				$error("result with no matrix outstanding");
			end else begin
				exp_res = inverse_q.pop_front();
				if (exp_res.sing) singular_seen <= singular_seen + 1;
				if (exp_res.ovf) overflow_seen <= overflow_seen + 1;
				for (int i = 0; i < 9; i++) begin
					got = m_tdata[i*32 +: 32];
					if (got !== exp_res.inv[i]) begin
						bad++;
						$error("inv_r%0dc%0d: expected %h, got %h", i/3, i%3,
							exp_res.inv[i], got);
					end
				end
				if (m_tdata[288 +: 32] !== exp_res.det) begin
					bad++;
					$error("determinant: expected %h, got %h", exp_res.det,
						m_tdata[288 +: 32]);
				end
				if (m_tuser[0] !== exp_res.sing) begin
					bad++;
					$error("singular: expected %b, got %b", exp_res.sing, m_tuser[0]);
				end
				if (m_tuser[1] !== exp_res.ovf) begin
					bad++;
					$error("overflow: expected %b, got %b", exp_res.ovf, m_tuser[1]);
				end
			end
		end
		if (bad != 0)
			errors <= errors + bad;
	end

	// End of run: drain, settle, report.
	initial begin
		wait (stim_done && inverse_q.size() == 0);
		repeat (LAT + 10) @(posedge clk);
		$display("Checked %0d matrix results: %0d singular, %0d saturated.",
			results_seen, singular_seen, overflow_seen);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Timeout guard.
	initial begin
		wait (cycles >= LIMIT);
		$display("Timed out after %0d cycles.", cycles);
		$display("status: fail");
		$finish;
	end

endmodule

>>> matrix3_inverse_top.f
+incdir+src
src/m3i_pkg.sv
src/m3i_cof_lane.sv
src/m3i_div_lane.sv
src/matrix3_inverse_top.sv
test/tb.sv
